/* hdl/cru_pkg.sv */
package cru_pkg;

  localparam int MAX_SIZE   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int AW     = $clog2(MAX_SIZE);
  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int CFG_W  = 7;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int SAT_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;

  localparam logic [CFG_W-1:0] MS_RESET = 7'd64;
  localparam logic signed [VAL_W-1:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ELEM = 1'b1;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd30;

  typedef enum logic [3:0] {
    S_IDLE, S_RDU, S_NORM, S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_DIVC_GO, S_DIVC_WAIT,
    S_DIVS_GO, S_DIVS_WAIT, S_ROT, S_OUT
  } state_t;

  typedef enum logic {ITER_SQRT, ITER_DIV} iter_op_t;

  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] x;
    logic [31:0] d;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } iter_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } rs_t;

  // Rounds a Q20.46 sum to Q16.16 (halves toward plus infinity) and saturates.
  function automatic rs_t round_sat(input logic signed [PROD_W-1:0] a);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    rs_t r;
    t  = a + $signed(PROD_W'(1) << 29);
    q  = t >>> 30;
    hi = $signed((PROD_W'(1) << (SAT_W - 1)) - PROD_W'(1));
    lo = ~hi;
    r.sat = 1'b0;
    if (q > hi) begin
      r.val = hi[VAL_W-1:0];
      r.sat = 1'b1;
    end else if (q < lo) begin
      r.val = lo[VAL_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = q[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/cru_in_if.sv */
interface cru_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic signed [cru_pkg::VAL_W-1:0] value;

  modport source(output valid, output operation, output value, input ready);
  modport sink(input valid, input operation, input value, output ready);
endinterface

/* hdl/cru_out_if.sv */
interface cru_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cru_pkg::VAL_W-1:0] updated_value;
  logic [cru_pkg::IDX_W-1:0]       row_index;
  logic [cru_pkg::IDX_W-1:0]       col_index;
  logic                            saturated;
  logic                            last_element;

  modport source(output valid, output updated_value, output row_index, output col_index,
                 output saturated, output last_element, input ready);
  modport sink(input valid, input updated_value, input row_index, input col_index,
               input saturated, input last_element, output ready);
endinterface

/* hdl/cru_ram.sv */
module cru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/cru_mul.sv */
module cru_mul (
  input  logic                                clk,
  input  logic signed [cru_pkg::OPND_W-1:0]   a,
  input  logic signed [cru_pkg::OPND_W-1:0]   b,
  output logic signed [cru_pkg::PROD_W-1:0]   prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

/* hdl/cru_iter.sv */
module cru_iter (
  input  logic               clk,
  input  logic               rst,
  input  cru_pkg::iter_req_t req,
  output cru_pkg::iter_rsp_t rsp
);
  logic              busy;
  logic              done;
  cru_pkg::iter_op_t op_q;
  logic [4:0]        cnt;
  logic [35:0]       rem;
  logic [63:0]       xs;
  logic [31:0]       d_q;
  logic [31:0]       res;
  logic [35:0]       sh;
  logic [35:0]       trial;
  logic              ge;
  logic [4:0]        last_cnt;

  // Square root takes two radicand bits a step, division one numerator bit.
  always_comb begin
    if (op_q == cru_pkg::ITER_SQRT) begin
      sh       = {rem[33:0], xs[63:62]};
      trial    = {2'b00, res, 2'b01};
      last_cnt = cru_pkg::SQRT_LAST;
    end else begin
      sh       = {rem[34:0], xs[63]};
      trial    = {4'b0000, d_q};
      last_cnt = cru_pkg::DIV_LAST;
    end
    ge = (sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_q <= req.op;
        d_q  <= req.d;
        res  <= '0;
        if (req.op == cru_pkg::ITER_SQRT) begin
          rem <= '0;
          xs  <= req.x;
        end else begin
          // The quotient stays below 2^31, so the top numerator bits start the remainder.
          rem <= {5'b00000, req.x[61:31]};
          xs  <= {req.x[30:0], 33'b0};
        end
      end else if (busy) begin
        rem <= ge ? (sh - trial) : sh;
        res <= {res[30:0], ge};
        xs  <= (op_q == cru_pkg::ITER_SQRT) ? (xs << 2) : (xs << 1);
        cnt <= cnt + 5'd1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;
endmodule

/* hdl/cholesky_rank_one_update_core.sv */
// Rank-one update of an upper-triangular Cholesky factor by Givens rotations.
// Channel items carries loads (operation 0, one entry of the update vector
// each) and matrix elements (operation 1) in row-major order; channel results
// returns one transaction per matrix element with its position and flags.
// Loads give no result. cfg_we/cfg_data write the matrix order and restart
// the load and element counters; write it only while the block is idle.
// An element on or above the diagonal has the shared 33x33 multiplier form four
// products in turn. For a diagonal element with a nonzero vector entry,
// normalization shifts one bit a cycle, then the iterative unit computes the
// hypotenuse root and two quotients one bit a cycle. The block takes a new
// transaction only when the previous one is finished, and a result waits in
// the output register while the receiver stalls, so a stall holds the block
// after its next element.
// Reset (rst, synchronous) clears the counters, empties the output register
// and sets the order to 64; the vector store holds no value until loaded.
module cholesky_rank_one_update_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cru_pkg::CFG_W-1:0]  cfg_data,
  cru_in_if.sink                     items,
  cru_out_if.source                  results
);
  cru_pkg::state_t state, state_next;

  logic [cru_pkg::CFG_W-1:0]         mat_order;
  logic [cru_pkg::CNT_W-1:0]         n;
  logic [cru_pkg::CNT_W-1:0]         load_count;
  logic [cru_pkg::AW-1:0]            row_count;
  logic [cru_pkg::AW-1:0]            col_count;
  logic signed [cru_pkg::VAL_W-1:0]  v_q;
  logic signed [cru_pkg::VAL_W-1:0]  ui_q;
  logic signed [cru_pkg::VAL_W-1:0]  cs;
  logic signed [cru_pkg::VAL_W-1:0]  sn;
  logic [31:0]                       ua;
  logic [31:0]                       ub;
  logic [31:0]                       hyp;
  logic [31:0]                       cm;
  logic [63:0]                       sq;
  logic signed [cru_pkg::PROD_W-1:0] acc_r;
  logic signed [cru_pkg::PROD_W-1:0] acc_u;
  logic signed [cru_pkg::PROD_W-1:0] prod;
  logic [2:0]                        step;
  logic                              pass_q;

  logic                              out_valid;
  logic signed [cru_pkg::VAL_W-1:0]  out_val;
  logic [cru_pkg::IDX_W-1:0]         out_row;
  logic [cru_pkg::IDX_W-1:0]         out_col;
  logic                              out_sat;
  logic                              out_last;

  logic                              accept;
  logic                              load_wr;
  logic                              fire;
  logic                              diag;
  logic                              below;
  logic                              last_col;
  logic                              last_row;
  logic                              norm_done;
  logic                              ram_we;
  logic [cru_pkg::AW-1:0]            ram_waddr;
  logic [cru_pkg::VAL_W-1:0]         ram_wdata;
  logic [cru_pkg::VAL_W-1:0]         ram_rdata;
  logic signed [cru_pkg::OPND_W-1:0] mul_a;
  logic signed [cru_pkg::OPND_W-1:0] mul_b;
  logic [63:0]                       num_c;
  logic [63:0]                       num_s;
  cru_pkg::iter_req_t                iter_req;
  cru_pkg::iter_rsp_t                iter_rsp;
  cru_pkg::rs_t                      rs_r;
  cru_pkg::rs_t                      rs_u;

  cru_ram #(.WIDTH(cru_pkg::VAL_W), .DEPTH(cru_pkg::MAX_SIZE)) u_vec (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col_count),
    .rdata (ram_rdata)
  );

  cru_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cru_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (iter_req),
    .rsp (iter_rsp)
  );

  always_comb begin
    if (mat_order == '0) begin
      n = cru_pkg::CNT_W'(1);
    end else if (int'(mat_order) > cru_pkg::MAX_SIZE) begin
      n = cru_pkg::CNT_W'(cru_pkg::MAX_SIZE);
    end else begin
      n = cru_pkg::CNT_W'(mat_order);
    end
  end

  assign accept    = items.valid && items.ready;
  assign load_wr   = accept && (items.operation == cru_pkg::OP_LOAD) && (load_count < n);
  assign diag      = (col_count == row_count);
  assign below     = (col_count < row_count);
  assign last_col  = (cru_pkg::CNT_W'(col_count) == n - cru_pkg::CNT_W'(1));
  assign last_row  = (cru_pkg::CNT_W'(row_count) == n - cru_pkg::CNT_W'(1));
  assign norm_done = |{ua[31:30], ub[31:30]};
  assign num_c     = {2'b00, ua, 30'b0} + {33'b0, hyp[31:1]};
  assign num_s     = {2'b00, ub, 30'b0} + {33'b0, hyp[31:1]};
  assign rs_r      = cru_pkg::round_sat(acc_r);
  assign rs_u      = cru_pkg::round_sat(acc_u);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cru_pkg::S_IDLE: begin
        if (accept && (items.operation == cru_pkg::OP_ELEM)) begin
          state_next = below ? cru_pkg::S_OUT : cru_pkg::S_RDU;
        end
      end
      cru_pkg::S_RDU: begin
        state_next = (diag && (ram_rdata != '0)) ? cru_pkg::S_NORM : cru_pkg::S_ROT;
      end
      cru_pkg::S_NORM: begin
        if (norm_done) begin
          state_next = cru_pkg::S_SQ;
        end
      end
      cru_pkg::S_SQ: begin
        if (step == 3'd2) begin
          state_next = cru_pkg::S_SQRT_GO;
        end
      end
      cru_pkg::S_SQRT_GO: state_next = cru_pkg::S_SQRT_WAIT;
      cru_pkg::S_SQRT_WAIT: begin
        if (iter_rsp.done) begin
          state_next = cru_pkg::S_DIVC_GO;
        end
      end
      cru_pkg::S_DIVC_GO: state_next = cru_pkg::S_DIVC_WAIT;
      cru_pkg::S_DIVC_WAIT: begin
        if (iter_rsp.done) begin
          state_next = cru_pkg::S_DIVS_GO;
        end
      end
      cru_pkg::S_DIVS_GO: state_next = cru_pkg::S_DIVS_WAIT;
      cru_pkg::S_DIVS_WAIT: begin
        if (iter_rsp.done) begin
          state_next = cru_pkg::S_ROT;
        end
      end
      cru_pkg::S_ROT: begin
        if (step == 3'd4) begin
          state_next = cru_pkg::S_OUT;
        end
      end
      cru_pkg::S_OUT: begin
        if (fire) begin
          state_next = cru_pkg::S_IDLE;
        end
      end
      default: state_next = cru_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    items.ready  = (state == cru_pkg::S_IDLE);
    fire         = (state == cru_pkg::S_OUT) && (!out_valid || results.ready);
    mul_a        = '0;
    mul_b        = '0;
    iter_req     = '0;
    iter_req.d   = hyp;
    ram_we       = load_wr || (fire && !pass_q);
    ram_waddr    = load_wr ? cru_pkg::AW'(load_count) : col_count;
    ram_wdata    = load_wr ? items.value : rs_u.val;
    case (state)
      cru_pkg::S_SQ: begin
        if (step == 3'd0) begin
          mul_a = $signed({1'b0, ua});
          mul_b = $signed({1'b0, ua});
        end else begin
          mul_a = $signed({1'b0, ub});
          mul_b = $signed({1'b0, ub});
        end
      end
      cru_pkg::S_ROT: begin
        case (step)
          3'd0: begin
            mul_a = cru_pkg::OPND_W'(cs);
            mul_b = cru_pkg::OPND_W'(v_q);
          end
          3'd1: begin
            mul_a = cru_pkg::OPND_W'(sn);
            mul_b = cru_pkg::OPND_W'(ui_q);
          end
          3'd2: begin
            mul_a = cru_pkg::OPND_W'(sn);
            mul_b = cru_pkg::OPND_W'(v_q);
          end
          3'd3: begin
            mul_a = cru_pkg::OPND_W'(cs);
            mul_b = cru_pkg::OPND_W'(ui_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      cru_pkg::S_SQRT_GO: begin
        iter_req.start = 1'b1;
        iter_req.op    = cru_pkg::ITER_SQRT;
        iter_req.x     = sq;
      end
      cru_pkg::S_DIVC_GO: begin
        iter_req.start = 1'b1;
        iter_req.op    = cru_pkg::ITER_DIV;
        iter_req.x     = num_c;
      end
      cru_pkg::S_DIVS_GO: begin
        iter_req.start = 1'b1;
        iter_req.op    = cru_pkg::ITER_DIV;
        iter_req.x     = num_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cru_pkg::S_IDLE;
      step        <= '0;
      mat_order   <= cru_pkg::MS_RESET;
      load_count  <= '0;
      row_count   <= '0;
      col_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      step  <= ((state == cru_pkg::S_SQ) || (state == cru_pkg::S_ROT)) ? step + 3'd1 : 3'd0;
      if (cfg_we) begin
        mat_order   <= cfg_data;
        load_count  <= '0;
        row_count   <= '0;
        col_count   <= '0;
      end else begin
        if (load_wr) begin
          load_count <= load_count + cru_pkg::CNT_W'(1);
        end
        if (fire) begin
          if (last_col) begin
            col_count <= '0;
            if (last_row) begin
              row_count  <= '0;
              load_count <= '0;
            end else begin
              row_count <= row_count + cru_pkg::AW'(1);
            end
          end else begin
            col_count <= col_count + cru_pkg::AW'(1);
          end
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_q    <= items.value;
      pass_q <= below;
    end
    case (state)
      cru_pkg::S_RDU: begin
        ui_q <= ram_rdata;
        ua   <= v_q[31] ? $unsigned(-v_q) : $unsigned(v_q);
        ub   <= ram_rdata[31] ? (~ram_rdata + 32'd1) : ram_rdata;
        if (diag && (ram_rdata == '0)) begin
          cs <= cru_pkg::ONE_Q30;
          sn <= '0;
        end
      end
      cru_pkg::S_NORM: begin
        if (!norm_done) begin
          ua <= ua << 1;
          ub <= ub << 1;
        end
      end
      cru_pkg::S_SQ: begin
        if (step == 3'd1) begin
          sq <= prod[63:0];
        end else if (step == 3'd2) begin
          sq <= sq + prod[63:0];
        end
      end
      cru_pkg::S_SQRT_WAIT: begin
        if (iter_rsp.done) begin
          hyp <= iter_rsp.res;
        end
      end
      cru_pkg::S_DIVC_WAIT: begin
        if (iter_rsp.done) begin
          cm <= iter_rsp.res;
        end
      end
      cru_pkg::S_DIVS_WAIT: begin
        if (iter_rsp.done) begin
          cs <= v_q[31] ? -$signed(cm) : $signed(cm);
          sn <= ui_q[31] ? $signed(iter_rsp.res) : -$signed(iter_rsp.res);
        end
      end
      cru_pkg::S_ROT: begin
        case (step)
          3'd1: acc_r <= prod;
          3'd2: acc_r <= acc_r - prod;
          3'd3: acc_u <= prod;
          3'd4: acc_u <= acc_u + prod;
          default: acc_u <= acc_u;
        endcase
      end
      default: begin
        hyp <= hyp;
      end
    endcase
    if (fire) begin
      out_val  <= pass_q ? v_q : $signed(rs_r.val);
      out_sat  <= !pass_q && (rs_r.sat || rs_u.sat);
      out_row  <= cru_pkg::IDX_W'(row_count);
      out_col  <= cru_pkg::IDX_W'(col_count);
      out_last <= last_col && last_row;
    end
  end

  assign results.valid         = out_valid;
  assign results.updated_value = out_val;
  assign results.row_index     = out_row;
  assign results.col_index     = out_col;
  assign results.saturated     = out_sat;
  assign results.last_element  = out_last;
endmodule

/* hdl/cru_checker.sv */
module cru_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_operation,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [cru_pkg::IDX_W-1:0] out_row,
  input logic [cru_pkg::IDX_W-1:0] out_col,
  input logic                      out_sat,
  input logic                      out_last
);
  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Taking a matrix element makes the block busy, so it is not ready for another.
  a_elem_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_operation == cru_pkg::OP_ELEM) |=> !in_ready)
    else $error("new transaction taken while an element is in work");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> (out_row == out_col))
    else $error("last element is off the diagonal");

  // Elements below the diagonal pass through and never saturate.
  a_sat_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |-> (out_col >= out_row))
    else $error("saturation flagged below the diagonal");
endmodule

bind cholesky_rank_one_update_core cru_checker u_cru_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .in_operation (items.operation),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_row      (results.row_index),
  .out_col      (results.col_index),
  .out_sat      (results.saturated),
  .out_last     (results.last_element)
);
